// ===== src/stsm_pkg.sv =====
// Shared types and constants for the sorted twin set mover.
// Holds the word formats, operation and status codes, controller states and
// the command and status groups between controller and datapath.
package stsm_pkg;

  localparam int MaxPaths  = 16;
  localparam int IndexBits = 8;
  localparam int CfgW      = 5;
  localparam int CntW      = $clog2(MaxPaths + 1);
  localparam int LimW      = (CntW > CfgW) ? CntW : CfgW;

  localparam logic [CfgW-1:0] CapReset = CfgW'(16);

  typedef enum logic [1:0] {
    OP_ADD_AVAIL = 2'd0,
    OP_ADD_FULL  = 2'd1,
    OP_MOVE_F2A  = 2'd2,
    OP_MOVE_A2F  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_INSERT,
    S_REPLY
  } state_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] path_index;
  } in_word_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] avail_count;
    logic [4:0] full_count;
  } out_word_t;

  typedef struct packed {
    logic    capture;
    logic    sel_full;
    logic    do_insert;
    logic    do_remove;
    logic    set_status;
    status_e status;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    found;
    logic    exists;
    logic    no_space;
    logic    out_busy;
  } dp_stat_t;

endpackage

// ===== src/stsm_datapath.sv =====
// Datapath of the sorted twin set mover: both sorted sets as rows of cells,
// the capacity register, the parallel compare, shift logic and result register.
// Depends on stsm_pkg.
module stsm_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stsm_pkg::in_word_t     in_word_i,
  input  logic                   cfg_we_i,
  input  logic [4:0]             cfg_wdata_i,
  input  stsm_pkg::dp_cmd_t      cmd_i,
  output stsm_pkg::dp_stat_t     stat_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output stsm_pkg::out_word_t    out_word_o
);
  import stsm_pkg::*;

  logic [IndexBits-1:0] avail_q [MaxPaths];
  logic [IndexBits-1:0] full_q  [MaxPaths];
  logic [CntW-1:0]      avail_size_q, full_size_q;
  logic [CfgW-1:0]      cap_q;
  opcode_e              op_q;
  logic [IndexBits-1:0] idx_q;
  status_e              status_q;
  logic                 out_valid_q;
  out_word_t            out_word_q;

  logic [IndexBits-1:0] cur     [MaxPaths];
  logic [IndexBits-1:0] cur_up  [MaxPaths];
  logic [IndexBits-1:0] cur_dn  [MaxPaths];
  logic [IndexBits-1:0] new_row [MaxPaths];
  logic [CntW-1:0]      cur_size;
  logic [MaxPaths-1:0]  lower, prev_lower, match, at_or_above;
  logic [LimW-1:0]      limit;

  always_comb begin
    cur_size = cmd_i.sel_full ? full_size_q : avail_size_q;
    for (int k = 0; k < MaxPaths; k++) begin
      cur[k] = cmd_i.sel_full ? full_q[k] : avail_q[k];
    end
    for (int k = 0; k < MaxPaths; k++) begin
      lower[k]       = (k < int'(cur_size)) && (cur[k] < idx_q);
      match[k]       = (k < int'(cur_size)) && (cur[k] == idx_q);
      at_or_above[k] = (k < int'(cur_size)) && (cur[k] >= idx_q);
    end
    prev_lower[0] = 1'b1;
    cur_dn[0]     = idx_q;
    for (int k = 1; k < MaxPaths; k++) begin
      prev_lower[k] = lower[k-1];
      cur_dn[k]     = cur[k-1];
    end
    for (int k = 0; k < MaxPaths - 1; k++) begin
      cur_up[k] = cur[k+1];
    end
    cur_up[MaxPaths-1] = cur[MaxPaths-1];
    for (int k = 0; k < MaxPaths; k++) begin
      if (cmd_i.do_insert) begin
        new_row[k] = lower[k] ? cur[k] : (prev_lower[k] ? idx_q : cur_dn[k]);
      end else begin
        new_row[k] = at_or_above[k] ? cur_up[k] : cur[k];
      end
    end
    limit = (LimW'(cap_q) < LimW'(MaxPaths)) ? LimW'(cap_q) : LimW'(MaxPaths);
  end

  assign stat_o.op       = op_q;
  assign stat_o.found    = |match;
  assign stat_o.exists   = |match;
  assign stat_o.no_space = LimW'(cur_size) >= limit;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= in_word_i.opcode;
      idx_q <= in_word_i.path_index[IndexBits-1:0];
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.load_out) begin
      out_word_q.status      <= status_q;
      out_word_q.avail_count <= 5'(avail_size_q);
      out_word_q.full_count  <= 5'(full_size_q);
    end
    if (cmd_i.do_insert || cmd_i.do_remove) begin
      for (int k = 0; k < MaxPaths; k++) begin
        if (cmd_i.sel_full) begin
          full_q[k] <= new_row[k];
        end else begin
          avail_q[k] <= new_row[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_size_q <= '0;
      full_size_q  <= '0;
      cap_q        <= CapReset;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.do_insert) begin
        if (cmd_i.sel_full) begin
          full_size_q <= full_size_q + CntW'(1);
        end else begin
          avail_size_q <= avail_size_q + CntW'(1);
        end
      end else if (cmd_i.do_remove) begin
        if (cmd_i.sel_full) begin
          full_size_q <= full_size_q - CntW'(1);
        end else begin
          avail_size_q <= avail_size_q - CntW'(1);
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== src/stsm_ctrl.sv =====
// Controller of the sorted twin set mover: sequences capture, removal,
// insertion and reply for one word at a time.
// Depends on stsm_pkg.
module stsm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stsm_pkg::in_word_t in_word_i,
  input  stsm_pkg::dp_stat_t stat_i,
  output stsm_pkg::dp_cmd_t  cmd_o
);
  import stsm_pkg::*;

  state_e state_q, state_d;
  logic   dest_full;

  assign dest_full = (stat_i.op == OP_ADD_FULL) || (stat_i.op == OP_MOVE_A2F);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if ((in_word_i.opcode == OP_ADD_AVAIL) || (in_word_i.opcode == OP_ADD_FULL)) begin
            state_d = S_INSERT;
          end else begin
            state_d = S_REMOVE;
          end
        end
      end
      S_REMOVE: state_d = stat_i.found ? S_INSERT : S_REPLY;
      S_INSERT: state_d = S_REPLY;
      S_REPLY: begin
        if (!stat_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.status = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_REMOVE: begin
        cmd_o.sel_full = (stat_i.op == OP_MOVE_F2A);
        if (stat_i.found) begin
          cmd_o.do_remove = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_NOT_FOUND;
        end
      end
      S_INSERT: begin
        cmd_o.sel_full   = dest_full;
        cmd_o.set_status = 1'b1;
        if (stat_i.exists) begin
          cmd_o.status = ST_EXISTS;
        end else if (stat_i.no_space) begin
          cmd_o.status = ST_NO_SPACE;
        end else begin
          cmd_o.status    = ST_OK;
          cmd_o.do_insert = 1'b1;
        end
      end
      S_REPLY: begin
        cmd_o.load_out = !stat_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/sorted_twin_set_mover.sv =====
// An add passes through the insert state, a move whose index is missing from the
// source set through the remove state, and a move that finds its index through
// remove and then insert, before the reply state loads the result word into the
// output register. The controller handles one word at a time and returns to idle
// before it accepts the next. The parallel compare and shift works across the
// cells of one set for each removal or insertion. A new word is accepted while the
// previous result still waits in the output register. The result of that new word
// is loaded only once the register has been taken, so a receiver that holds off
// stalls the input from then on. Both sets start empty after reset and the capacity
// register starts at sixteen.
// Top level of the sorted twin set mover; depends on stsm_pkg, stsm_ctrl and
// stsm_datapath.
module sorted_twin_set_mover (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  stsm_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stsm_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i
);
  import stsm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  stsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== test/stsm_set_checker.sv =====
`timescale 1ns / 100ps
// Checker for the sorted twin set mover: keeps its own copy of both sorted sets
// and the capacity, predicts each result word and compares them in order.
// Depends on stsm_pkg.
module stsm_set_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  stsm_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  stsm_pkg::out_word_t out_word_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  output int                  fails_o,
  output int                  pending_o
);
  import stsm_pkg::*;

  localparam int AvailSet = 0;
  localparam int FullSet  = 1;

  logic [7:0]  members [2][MaxPaths];
  int unsigned set_size [2];
  int unsigned capacity;
  out_word_t   expected_words [$];
  out_word_t   oldest;
  int          fail_count;

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic int unsigned path_limit();
    return (capacity < MaxPaths) ? capacity : MaxPaths;
  endfunction

  function automatic status_e insert_path(int s, logic [7:0] v);
    int unsigned pos;
    int unsigned k;
    bit          stop;
    pos  = 0;
    stop = 1'b0;
    while (!stop && pos < set_size[s]) begin
      if (v == members[s][pos]) return ST_EXISTS;
      if (v < members[s][pos]) stop = 1'b1;
      else pos++;
    end
    if (set_size[s] >= path_limit()) return ST_NO_SPACE;
    for (k = set_size[s]; k > pos; k--) members[s][k] = members[s][k-1];
    members[s][pos] = v;
    set_size[s]++;
    return ST_OK;
  endfunction

  function automatic bit remove_path(int s, logic [7:0] v);
    int unsigned pos;
    int unsigned k;
    pos = 0;
    while (pos < set_size[s] && members[s][pos] != v) pos++;
    if (pos >= set_size[s]) return 1'b0;
    for (k = pos + 1; k < set_size[s]; k++) members[s][k-1] = members[s][k];
    set_size[s]--;
    return 1'b1;
  endfunction

  function automatic out_word_t apply_set_op(in_word_t w);
    out_word_t res;
    status_e   st;
    case (w.opcode)
      OP_ADD_AVAIL: st = insert_path(AvailSet, w.path_index);
      OP_ADD_FULL:  st = insert_path(FullSet, w.path_index);
      OP_MOVE_F2A: begin
        if (remove_path(FullSet, w.path_index)) st = insert_path(AvailSet, w.path_index);
        else st = ST_NOT_FOUND;
      end
      default: begin
        if (remove_path(AvailSet, w.path_index)) st = insert_path(FullSet, w.path_index);
        else st = ST_NOT_FOUND;
      end
    endcase
    res.status      = st;
    res.avail_count = 5'(set_size[AvailSet]);
    res.full_count  = 5'(set_size[FullSet]);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size[AvailSet] = 0;
      set_size[FullSet]  = 0;
      capacity           = 32'(CapReset);
      expected_words.delete();
      fail_count         = 0;
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          flag_error($sformatf("result word %h with nothing expected", out_word_i));
        end else begin
          oldest = expected_words.pop_front();
          if (out_word_i.status != oldest.status)
            flag_error($sformatf("status %0d, expected %0d",
                                 out_word_i.status, oldest.status));
          if (out_word_i.avail_count != oldest.avail_count)
            flag_error($sformatf("avail_count %0d, expected %0d",
                                 out_word_i.avail_count, oldest.avail_count));
          if (out_word_i.full_count != oldest.full_count)
            flag_error($sformatf("full_count %0d, expected %0d",
                                 out_word_i.full_count, oldest.full_count));
        end
      end
      if (in_valid_i && in_ready_i) expected_words.push_back(apply_set_op(in_word_i));
      if (cfg_we_i) capacity = 32'(cfg_wdata_i);
      fails_o   <= fail_count;
      pending_o <= expected_words.size();
    end
  end

endmodule

// ===== test/sorted_twin_set_mover_tb.sv =====
`timescale 1ns / 100ps
// Top of the sorted twin set mover testbench: drives directed and random words
// under several idling patterns and capacity settings and gives the verdict.
// Depends on stsm_pkg, sorted_twin_set_mover and stsm_set_checker.
module sorted_twin_set_mover_tb;
  import stsm_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseCount  = 8;
  localparam int PhaseWords  = 215;
  localparam int HoldCycles  = 80;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_word_t   in_word_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_word_t  out_word_o;
  logic       cfg_we_i    = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  int fails;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_seq   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sorted_twin_set_mover uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  stsm_set_checker u_set_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_i  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  // The receiver owns its hold-off counter; a new request is signalled by a
  // change of the sequence number.
  initial begin : receiver
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    forever begin
      @(posedge clk_i);
      if (seen_seq != hold_req_seq) begin
        seen_seq  = hold_req_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_word_t path_op(opcode_e op, logic [7:0] idx);
    in_word_t w;
    w.opcode     = op;
    w.path_index = idx;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_capacity(logic [4:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  initial begin : stimulus
    logic [4:0] phase_caps [PhaseCount];
    logic [7:0] path_pool [24];
    int         pool_n;
    in_word_t   w;
    phase_caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd9, 5'd16, 5'd2, 5'd31};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(path_op(OP_ADD_AVAIL, 8'd0));
    send_word(path_op(OP_ADD_AVAIL, 8'd255));
    send_word(path_op(OP_ADD_AVAIL, 8'd128));
    send_word(path_op(OP_ADD_AVAIL, 8'd128));
    send_word(path_op(OP_ADD_FULL, 8'd255));
    send_word(path_op(OP_ADD_FULL, 8'd0));
    send_word(path_op(OP_MOVE_A2F, 8'd128));
    send_word(path_op(OP_MOVE_A2F, 8'd128));
    send_word(path_op(OP_MOVE_F2A, 8'd7));
    send_word(path_op(OP_MOVE_A2F, 8'd0));
    send_word(path_op(OP_MOVE_F2A, 8'd255));
    // Capacity now below the count of the full set.
    write_capacity(5'd1);
    send_word(path_op(OP_ADD_AVAIL, 8'd10));
    send_word(path_op(OP_ADD_FULL, 8'd128));
    send_word(path_op(OP_MOVE_F2A, 8'd0));
    send_word(path_op(OP_MOVE_A2F, 8'd255));
    write_capacity(5'd0);
    send_word(path_op(OP_ADD_AVAIL, 8'd1));
    send_word(path_op(OP_ADD_FULL, 8'd128));
    write_capacity(5'd31);
    send_word(path_op(OP_ADD_AVAIL, 8'd85));
    send_word(path_op(OP_ADD_AVAIL, 8'd170));
    send_word(path_op(OP_MOVE_A2F, 8'd170));

    for (int p = 0; p < PhaseCount; p++) begin
      write_capacity(phase_caps[p]);
      case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(45, 0);
        2: set_idling(0, 45);
        default: set_idling(13, 13);
      endcase
      pool_n = $urandom_range(4, 24);
      for (int i = 0; i < pool_n; i++) path_pool[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < PhaseWords; i++) begin
        if (i == 40 && (p == 0 || p == 5)) hold_req_seq <= hold_req_seq + 1;
        if (i == 100 && p == 4) wait_for_results();
        w.opcode = opcode_e'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 85) w.path_index = path_pool[$urandom_range(0, pool_n - 1)];
        else w.path_index = 8'($urandom_range(0, 255));
        send_word(w);
      end
    end

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
